@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by hsa_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hsa_pkg.sv @@
// ----------------------------------------------------------------------------
// hsa_pkg
// shared types and codes of the handle slot allocator
// ----------------------------------------------------------------------------
package hsa_pkg;

	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int SLOT_FIELD_W = 10;

	localparam logic [FUNC_W-1:0] OP_REGISTER   = 2'd0;
	localparam logic [FUNC_W-1:0] OP_UNREGISTER = 2'd1;
	localparam logic [FUNC_W-1:0] OP_LOOKUP     = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_READ
	} hsa_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic pop_done;
		logic read_done;
		logic load_out;
	} hsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_pop;
		logic need_read;
	} hsa_sts_t;

endpackage

@@ rtl/hsa_req_if.sv @@
// ----------------------------------------------------------------------------
// hsa_req_if
// request channel: valid/ready with function, reference and slot
// ----------------------------------------------------------------------------
interface hsa_req_if #(
	parameter int REF_BITS = 48
);
	logic                             valid;
	logic                             ready;
	logic [hsa_pkg::FUNC_W-1:0]       func;
	logic [REF_BITS-1:0]              object_ref;
	logic [hsa_pkg::SLOT_FIELD_W-1:0] slot_number;

	modport source (output valid, output func, output object_ref, output slot_number,
		input ready);
	modport sink (input valid, input func, input object_ref, input slot_number,
		output ready);
endinterface

@@ rtl/hsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hsa_rsp_if
// response channel: valid/ready with status, granted slot and found reference
// ----------------------------------------------------------------------------
interface hsa_rsp_if #(
	parameter int REF_BITS = 48
);
	logic                             valid;
	logic                             ready;
	logic [hsa_pkg::STATUS_W-1:0]     status;
	logic [hsa_pkg::SLOT_FIELD_W-1:0] granted_slot;
	logic [REF_BITS-1:0]              found_ref;

	modport source (output valid, output status, output granted_slot, output found_ref,
		input ready);
	modport sink (input valid, input status, input granted_slot, input found_ref,
		output ready);
endinterface

@@ rtl/hsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsa_ctrl
// sequencing state machine and response valid flag
// ----------------------------------------------------------------------------
module hsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  hsa_pkg::hsa_sts_t sts,
	output hsa_pkg::hsa_cmd_t cmd
);

	hsa_pkg::hsa_state_t state_q;
	hsa_pkg::hsa_state_t state_d;
	logic                out_valid_q;
	logic                accept;

	assign in_ready  = (state_q == hsa_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsa_pkg::S_IDLE: begin
				if (accept) begin
					priority if (sts.need_pop) begin
						state_d = hsa_pkg::S_POP;
					end else if (sts.need_read) begin
						state_d = hsa_pkg::S_READ;
					end else begin
						state_d = hsa_pkg::S_IDLE;
					end
				end
			end
			hsa_pkg::S_POP:  state_d = hsa_pkg::S_IDLE;
			hsa_pkg::S_READ: state_d = hsa_pkg::S_IDLE;
			default:         state_d = hsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept    = accept;
		cmd.pop_done  = (state_q == hsa_pkg::S_POP);
		cmd.read_done = (state_q == hsa_pkg::S_READ);
		cmd.load_out  = (accept && !sts.need_pop && !sts.need_read)
			|| cmd.pop_done || cmd.read_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hsa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/hsa_datapath.sv @@
// ----------------------------------------------------------------------------
// hsa_datapath
// reference table, free slot stack, counters and response registers
// ----------------------------------------------------------------------------
module hsa_datapath #(
	parameter int SLOTS    = 1024,
	parameter int REF_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hsa_pkg::hsa_cmd_t                cmd,
	output hsa_pkg::hsa_sts_t                sts,
	input  logic [hsa_pkg::FUNC_W-1:0]       func,
	input  logic [REF_BITS-1:0]              object_ref,
	input  logic [hsa_pkg::SLOT_FIELD_W-1:0] slot_number,
	output logic [hsa_pkg::STATUS_W-1:0]     status,
	output logic [hsa_pkg::SLOT_FIELD_W-1:0] granted_slot,
	output logic [REF_BITS-1:0]              found_ref
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = (CW > hsa_pkg::SLOT_FIELD_W) ? CW : hsa_pkg::SLOT_FIELD_W;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	logic [REF_BITS-1:0] ref_table [SLOTS];
	logic [SW-1:0]       free_stack [SLOTS];
	logic [REF_BITS-1:0] table_rd_q;
	logic [SW-1:0]       stack_rd_q;
	logic [REF_BITS-1:0] ref_q;
	logic [CW-1:0]       free_count_q;
	logic [CW-1:0]       next_fresh_q;

	logic [hsa_pkg::STATUS_W-1:0]     status_q;
	logic [hsa_pkg::SLOT_FIELD_W-1:0] granted_q;
	logic [REF_BITS-1:0]              found_q;

	logic                is_reg, is_unreg, is_lookup;
	logic                has_free, fresh_ok, stack_full, in_range;
	logic [XW-1:0]       slot_x, fresh_x, pop_x;
	logic [SW-1:0]       slot_idx, fresh_idx, push_idx;
	logic [CW-1:0]       fc_m1;

	logic                tbl_we, tbl_re, stk_we, stk_re;
	logic [SW-1:0]       tbl_wa, tbl_ra, stk_wa, stk_ra, stk_wd;
	logic [REF_BITS-1:0] tbl_wd;

	logic [hsa_pkg::STATUS_W-1:0]     res_status;
	logic [hsa_pkg::SLOT_FIELD_W-1:0] res_granted;
	logic [REF_BITS-1:0]              res_found;

	assign is_reg    = (func == hsa_pkg::OP_REGISTER);
	assign is_unreg  = (func == hsa_pkg::OP_UNREGISTER);
	assign is_lookup = (func == hsa_pkg::OP_LOOKUP);

	assign has_free   = (free_count_q != '0);
	assign fresh_ok   = (next_fresh_q != SLOTS_C);
	assign stack_full = (free_count_q == SLOTS_C);

	assign slot_x    = XW'(slot_number);
	assign fresh_x   = XW'(next_fresh_q);
	assign pop_x     = XW'(stack_rd_q);
	assign in_range  = (slot_x < fresh_x);
	assign slot_idx  = slot_x[SW-1:0];
	assign fresh_idx = next_fresh_q[SW-1:0];
	assign push_idx  = free_count_q[SW-1:0];
	assign fc_m1     = free_count_q - 1'b1;

	assign sts.need_pop  = is_reg && has_free;
	assign sts.need_read = is_lookup && in_range;

	// memory port control
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = '0;
		tbl_wd = '0;
		tbl_re = 1'b0;
		tbl_ra = '0;
		stk_we = 1'b0;
		stk_wa = '0;
		stk_wd = '0;
		stk_re = 1'b0;
		stk_ra = '0;
		if (cmd.accept) begin
			priority if (is_reg && has_free) begin
				stk_re = 1'b1;
				stk_ra = fc_m1[SW-1:0];
			end else if (is_reg && fresh_ok) begin
				tbl_we = 1'b1;
				tbl_wa = fresh_idx;
				tbl_wd = object_ref;
			end else if (is_unreg && in_range) begin
				tbl_we = 1'b1;
				tbl_wa = slot_idx;
				stk_we = !stack_full;
				stk_wa = push_idx;
				stk_wd = slot_idx;
			end else if (is_lookup && in_range) begin
				tbl_re = 1'b1;
				tbl_ra = slot_idx;
			end else begin
				tbl_we = 1'b0;
			end
		end
		if (cmd.pop_done) begin
			tbl_we = 1'b1;
			tbl_wa = stack_rd_q;
			tbl_wd = ref_q;
		end
	end

	// response of the finishing transaction
	always_comb begin
		res_status  = hsa_pkg::STAT_OK;
		res_granted = '0;
		res_found   = '0;
		priority if (cmd.pop_done) begin
			res_granted = pop_x[hsa_pkg::SLOT_FIELD_W-1:0];
		end else if (cmd.read_done) begin
			res_found = table_rd_q;
		end else if (is_reg) begin
			if (fresh_ok) begin
				res_granted = fresh_x[hsa_pkg::SLOT_FIELD_W-1:0];
			end else begin
				res_status = hsa_pkg::STAT_FULL;
			end
		end else if (is_unreg || is_lookup) begin
			if (!in_range) begin
				res_status = hsa_pkg::STAT_RANGE;
			end
		end else begin
			res_status = hsa_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			ref_table[tbl_wa] <= tbl_wd;
		end
		if (tbl_re) begin
			table_rd_q <= ref_table[tbl_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			free_stack[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stack_rd_q <= free_stack[stk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ref_q <= object_ref;
		end
		if (cmd.load_out) begin
			status_q  <= res_status;
			granted_q <= res_granted;
			found_q   <= res_found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= '0;
			next_fresh_q <= '0;
		end else if (cmd.accept) begin
			priority if (is_reg && has_free) begin
				free_count_q <= fc_m1;
			end else if (is_reg && fresh_ok) begin
				next_fresh_q <= next_fresh_q + 1'b1;
			end else if (is_unreg && in_range && !stack_full) begin
				free_count_q <= free_count_q + 1'b1;
			end else begin
				free_count_q <= free_count_q;
			end
		end
	end

	assign status       = status_q;
	assign granted_slot = granted_q;
	assign found_ref    = found_q;

endmodule

@@ rtl/handle_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// handle_slot_allocator
// free-list handle table mapping slot numbers to object references
// response: loaded from the accepted request itself for unregister,
//   fresh-slot register, full, out-of-range and unknown functions; a
//   register that reuses a freed slot and an in-range lookup first pass
//   through S_POP or S_READ for the registered free stack or table read
// throughput: requests are taken only in S_IDLE with no stalled response
// reset: arst_n clears the counters, state machine and response valid;
//   table and stack contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module handle_slot_allocator #(
	parameter int SLOTS    = 1024,
	parameter int REF_BITS = 48
) (
	input  logic     clk,
	input  logic     arst_n,
	hsa_req_if.sink  req,
	hsa_rsp_if.source rsp
);

	hsa_pkg::hsa_cmd_t cmd;
	hsa_pkg::hsa_sts_t sts;

	hsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hsa_datapath #(
		.SLOTS    (SLOTS),
		.REF_BITS (REF_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (req.func),
		.object_ref   (req.object_ref),
		.slot_number  (req.slot_number),
		.status       (rsp.status),
		.granted_slot (rsp.granted_slot),
		.found_ref    (rsp.found_ref)
	);

endmodule

@@ rtl/hsa_checker.sv @@
// ----------------------------------------------------------------------------
// hsa_checker
// port-level checks of the handle slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsa_checker #(
	parameter int REF_BITS = 48
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [hsa_pkg::STATUS_W-1:0]     status,
	input logic [hsa_pkg::SLOT_FIELD_W-1:0] granted_slot,
	input logic [REF_BITS-1:0]              found_ref
);

	// stalled response holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_slot) && $stable(found_ref), "stalled response changed")

	// an accepted transaction leaves the block busy or a response pending
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, out_valid || !in_ready, "accepted transaction produced nothing")

	// status is one of the defined codes
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid, status == hsa_pkg::STAT_OK || status == hsa_pkg::STAT_FULL || status == hsa_pkg::STAT_RANGE, "undefined status code")

	// failed transactions carry no slot and no reference
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, out_valid && status != hsa_pkg::STAT_OK, granted_slot == '0 && found_ref == '0, "failed response has payload")

endmodule

bind handle_slot_allocator hsa_checker #(
	.REF_BITS (REF_BITS)
) u_hsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.status       (rsp.status),
	.granted_slot (rsp.granted_slot),
	.found_ref    (rsp.found_ref)
);
